[src/aaar_pkg.sv]
// Shared types, constants and helpers for the affine area-average resampler.
package aaar_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ADDR_W     = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int COORD_W    = 54;
    localparam int POS_W      = 24;
    localparam int SPAN_W     = 17;
    localparam int PROD_W     = 49;
    localparam int DS_W       = 2 * SPAN_W;
    localparam int ACC_W      = 66;
    localparam int AREA_W     = 49;
    localparam int QUOT_W     = 16;
    localparam int DIM_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 48;

    localparam logic [DIM_W-1:0]      MAX_DIM = 9'd256;
    localparam logic [CFG_DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_XX, CFG_COEF_XY, CFG_COEF_YX, CFG_COEF_YY,
        CFG_OFFSET_X, CFG_OFFSET_Y, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT
    } t_cfg_idx;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic load_we;
        logic capture;
        logic map1;
        logic map2;
        logic map3;
        logic check;
        logic row_init;
        logic step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic undef;
        logic ident;
        logic last_pix;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    // Overlap of source cell idx with the span [lo, hi] on one axis.
    function automatic logic [SPAN_W-1:0] span_len(input logic [7:0] idx,
                                                    input logic [POS_W-1:0] lo,
                                                    input logic [POS_W-1:0] hi);
        logic [POS_W:0] top;
        logic [POS_W:0] bot;
        logic [POS_W:0] e;
        logic [POS_W:0] s;
        logic [POS_W:0] d;
        top = {1'b0, idx, 16'h0000};
        bot = top + 25'h001_0000;
        e   = (bot > {1'b0, hi}) ? {1'b0, hi} : bot;
        s   = (top < {1'b0, lo}) ? {1'b0, lo} : top;
        d   = e - s;
        return d[SPAN_W-1:0];
    endfunction

endpackage

[src/aaar_ctrl.sv]
// Sequencing state machine for the affine area-average resampler.
module aaar_ctrl
    import aaar_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tuser,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        IDLE, MAP1, MAP2, MAP3, CHECK, DECIDE, IREAD, ROWINIT,
        WALK, DRAIN, DIVINIT, DIVIDE, FINISH
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_drain, n_drain;
    logic       accept;

    assign o_s_tready = (r_state == IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        case (r_state)
            IDLE: begin
                if (accept && i_s_tuser == CMD_QUERY) n_state = MAP1;
            end
            MAP1:    n_state = MAP2;
            MAP2:    n_state = MAP3;
            MAP3:    n_state = CHECK;
            CHECK:   n_state = DECIDE;
            DECIDE: begin
                if (i_sts.undef)      n_state = FINISH;
                else if (i_sts.ident) n_state = IREAD;
                else                  n_state = ROWINIT;
            end
            IREAD:   n_state = FINISH;
            ROWINIT: n_state = WALK;
            WALK: begin
                if (i_sts.last_pix) begin
                    n_state = DRAIN;
                    n_drain = 2'd0;
                end
            end
            DRAIN: begin
                // hold until the three multiply/accumulate stages are empty
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'd2) n_state = DIVINIT;
            end
            DIVINIT: n_state = DIVIDE;
            DIVIDE: begin
                if (i_sts.div_last) n_state = FINISH;
            end
            FINISH: begin
                if (i_sts.out_free) n_state = IDLE;
            end
            default: n_state = IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_we  = accept && (i_s_tuser == CMD_LOAD);
        o_cmd.capture  = accept && (i_s_tuser == CMD_QUERY);
        o_cmd.map1     = (r_state == MAP1);
        o_cmd.map2     = (r_state == MAP2);
        o_cmd.map3     = (r_state == MAP3);
        o_cmd.check    = (r_state == CHECK);
        o_cmd.row_init = (r_state == ROWINIT);
        o_cmd.step     = (r_state == WALK);
        o_cmd.div_init = (r_state == DIVINIT);
        o_cmd.div_step = (r_state == DIVIDE);
        o_cmd.out_load = (r_state == FINISH) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
            r_drain <= 2'd0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

endmodule

[src/aaar_dp.sv]
// Datapath: configuration, pixel store, mapping, area walk, divider, output register.
module aaar_dp
    import aaar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser
);

    // configuration
    logic signed [31:0] r_cxx, r_cxy, r_cyx, r_cyy, r_cox, r_coy;
    logic [DIM_W-1:0]   r_iw, r_ih;
    logic [DIM_W-1:0]   w, h;
    logic [POS_W:0]     wq, hq;
    logic               is_ident;

    // mapping
    logic signed [16:0]        r_px, r_py;
    logic signed [PROD_W-1:0]  r_pxx, r_pxy, r_pyx, r_pyy;
    logic signed [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic [POS_W-1:0]          r_x0, r_x1, r_y0, r_y1;
    logic                      r_undef, r_ident;
    logic [ADDR_W-1:0]         r_iaddr;
    logic                      out_rng, id_ok;

    // walk
    logic [7:0]          r_row, r_col;
    logic [ADDR_W-1:0]   r_rbase;
    logic [SPAN_W-1:0]   r_dy, r_dx_s, r_dy_s;
    logic                r_v1, r_v2, r_v3;
    logic [DS_W-1:0]     r_ds, r_ds2;
    logic [OUT_DATA_W-1:0] r_pix;
    logic [PROD_W-1:0]   r_prod [3];
    logic [ACC_W-1:0]    r_acc [3];
    logic [AREA_W-1:0]   r_area;
    logic                col_end, row_end;

    // store
    logic [OUT_DATA_W-1:0] r_mem [STORE_DEPTH];
    logic [OUT_DATA_W-1:0] r_rdata;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;

    // divider
    logic [ACC_W-1:0]  r_rem [3];
    logic [QUOT_W-1:0] r_quot [3];
    logic [3:0]        r_dcnt;
    logic [ACC_W-1:0]  dsh;

    logic                  r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic                  r_o_def;
    logic [OUT_DATA_W-1:0] res_data;

    assign w        = (r_iw > MAX_DIM) ? MAX_DIM : r_iw;
    assign h        = (r_ih > MAX_DIM) ? MAX_DIM : r_ih;
    assign wq       = {w, 16'h0000};
    assign hq       = {h, 16'h0000};
    assign is_ident = (r_cxx == $signed(ONE_Q16)) && (r_cxy == 32'sd0) &&
                      (r_cyx == 32'sd0) && (r_cyy == $signed(ONE_Q16)) &&
                      (r_cox == 32'sd0) && (r_coy == 32'sd0);

    assign out_rng = r_sx[COORD_W-1] || (r_sx[COORD_W-2:0] >= (COORD_W-1)'(wq)) ||
                     r_sy[COORD_W-1] || (r_sy[COORD_W-2:0] >= (COORD_W-1)'(hq)) ||
                     r_ex[COORD_W-1] || (r_ex[COORD_W-2:0] >= (COORD_W-1)'(wq)) ||
                     r_ey[COORD_W-1] || (r_ey[COORD_W-2:0] >= (COORD_W-1)'(hq));
    assign id_ok   = !r_px[16] && (r_px[15:0] < {7'd0, w}) &&
                     !r_py[16] && (r_py[15:0] < {7'd0, h});

    assign col_end = (r_col == r_x1[POS_W-1:16]);
    assign row_end = (r_row == r_y1[POS_W-1:16]);
    assign rd_addr = r_ident ? r_iaddr : (r_rbase + {8'd0, r_col});
    assign wr_addr = i_s_tdata[15:0];
    assign dsh     = {{(ACC_W-AREA_W){1'b0}}, r_area} << r_dcnt;

    always_comb begin
        if (r_undef)        res_data = '0;
        else if (r_ident)   res_data = r_rdata;
        else if (r_area == '0) res_data = '0;
        else                res_data = {r_quot[2], r_quot[1], r_quot[0]};
    end

    assign o_sts.undef    = r_undef;
    assign o_sts.ident    = r_ident;
    assign o_sts.last_pix = col_end && row_end;
    assign o_sts.div_last = (r_dcnt == 4'd0);
    assign o_sts.out_free = !r_o_valid || i_m_tready;

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_def;

    // pixel store: write on load, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) r_mem[wr_addr] <= i_s_tdata[63:16];
        r_rdata <= r_mem[rd_addr];
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cxx <= $signed(ONE_Q16);
            r_cxy <= '0;
            r_cyx <= '0;
            r_cyy <= $signed(ONE_Q16);
            r_cox <= '0;
            r_coy <= '0;
            r_iw  <= MAX_DIM;
            r_ih  <= MAX_DIM;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_COEF_XX:      r_cxx <= $signed(i_cfg_data);
                    CFG_COEF_XY:      r_cxy <= $signed(i_cfg_data);
                    CFG_COEF_YX:      r_cyx <= $signed(i_cfg_data);
                    CFG_COEF_YY:      r_cyy <= $signed(i_cfg_data);
                    CFG_OFFSET_X:     r_cox <= $signed(i_cfg_data);
                    CFG_OFFSET_Y:     r_coy <= $signed(i_cfg_data);
                    CFG_IMAGE_WIDTH:  r_iw  <= i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: r_ih  <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.out_load)  r_o_valid <= 1'b1;
            else if (i_m_tready) r_o_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= {i_s_tdata[79], i_s_tdata[79:64]};
            r_py <= {i_s_tdata[95], i_s_tdata[95:80]};
        end
        if (i_cmd.map1) begin
            r_pxx <= r_cxx * r_px;
            r_pxy <= r_cxy * r_py;
            r_pyx <= r_cyx * r_px;
            r_pyy <= r_cyy * r_py;
        end
        if (i_cmd.map2) begin
            r_sx <= COORD_W'(r_pxx) + COORD_W'(r_pxy) + COORD_W'(r_cox);
            r_sy <= COORD_W'(r_pyx) + COORD_W'(r_pyy) + COORD_W'(r_coy);
        end
        if (i_cmd.map3) begin
            // far corner: one more step along both axes
            r_ex <= r_sx + COORD_W'(r_cxx) + COORD_W'(r_cxy);
            r_ey <= r_sy + COORD_W'(r_cyx) + COORD_W'(r_cyy);
        end
        if (i_cmd.check) begin
            r_ident <= is_ident;
            r_undef <= is_ident ? !id_ok : out_rng;
            r_iaddr <= 16'({8'd0, r_py[7:0]} * {7'd0, w}) + {8'd0, r_px[7:0]};
            if (r_sx <= r_ex) begin
                r_x0 <= r_sx[POS_W-1:0];
                r_x1 <= r_ex[POS_W-1:0];
            end else begin
                r_x0 <= r_ex[POS_W-1:0];
                r_x1 <= r_sx[POS_W-1:0];
            end
            if (r_sy <= r_ey) begin
                r_y0 <= r_sy[POS_W-1:0];
                r_y1 <= r_ey[POS_W-1:0];
            end else begin
                r_y0 <= r_ey[POS_W-1:0];
                r_y1 <= r_sy[POS_W-1:0];
            end
        end
        if (i_cmd.row_init) begin
            r_row   <= r_y0[POS_W-1:16];
            r_col   <= r_x0[POS_W-1:16];
            r_rbase <= 16'({8'd0, r_y0[POS_W-1:16]} * {7'd0, w});
            r_dy    <= span_len(r_y0[POS_W-1:16], r_y0, r_y1);
            r_area  <= '0;
            for (int c = 0; c < 3; c++) r_acc[c] <= '0;
        end
        if (i_cmd.step) begin
            r_dx_s <= span_len(r_col, r_x0, r_x1);
            r_dy_s <= r_dy;
            if (col_end) begin
                r_col <= r_x0[POS_W-1:16];
                if (!row_end) begin
                    r_row   <= r_row + 8'd1;
                    r_rbase <= r_rbase + {7'd0, w};
                    r_dy    <= span_len(r_row + 8'd1, r_y0, r_y1);
                end
            end else begin
                r_col <= r_col + 8'd1;
            end
        end
        // stage 1: cell area, sample captured from the store
        r_ds  <= r_dx_s * r_dy_s;
        r_pix <= r_rdata;
        // stage 2: weight each channel
        r_ds2 <= r_ds;
        for (int c = 0; c < 3; c++)
            r_prod[c] <= PROD_W'(r_ds[DS_W-2:0] * r_pix[c*SAMPLE_W +: SAMPLE_W]);
        // stage 3: accumulate
        if (r_v3) begin
            r_area <= r_area + AREA_W'(r_ds2);
            for (int c = 0; c < 3; c++) r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
        end
        if (i_cmd.div_init) begin
            r_dcnt <= 4'd15;
            for (int c = 0; c < 3; c++) begin
                r_rem[c]  <= r_acc[c];
                r_quot[c] <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - 4'd1;
            for (int c = 0; c < 3; c++) begin
                if (r_rem[c] >= dsh) begin
                    r_rem[c]          <= r_rem[c] - dsh;
                    r_quot[c][r_dcnt] <= 1'b1;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_o_data <= res_data;
            r_o_def  <= !r_undef;
        end
    end

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_init |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("divide started with pixels still in flight");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_o_valid || i_m_tready))
        else $error("result overwritten before it was taken");
    a_walk_general: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!r_undef && !r_ident))
        else $error("area walk on an undefined or identity query");

endmodule

[src/affine_area_average_resampler.sv]
// Top level of the affine area-average resampler.
//
//  channel | direction | handshake              | payload
//  s_*     | in        | i_s_tvalid/o_s_tready  | tuser cmd, tdata load and query fields
//  m_*     | out       | o_m_tvalid/i_m_tready  | tuser defined, tdata red/green/blue
//  cfg_*   | in        | i_cfg_valid/o_cfg_ready| register index and 32-bit value
//
// A load is taken in idle and written to the store. A query runs the mapping steps
// and the range check; an undefined one goes straight to the result, one on the
// identity transform reads a single store entry, and any other walks its covered
// source pixels, reading one store entry a cycle, drains the multiply/accumulate
// stages and runs the divider, which retires one quotient bit a cycle. One item is
// worked at a time; a finished result waits while the output register is still full,
// and the next item is taken once it is loaded there.
// Reset is synchronous, active low; the store is not cleared.
module affine_area_average_resampler
    import aaar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [15:0] load_index, [31:16] load_red, [47:32] load_green, [63:48] load_blue,
    // [79:64] query_x, [95:80] query_y
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [0] cmd
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [15:0] out_red, [31:16] out_green, [47:32] out_blue
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // [0] defined
    output logic                  o_m_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // registers are always writable; write them only while no item is in flight
    assign o_cfg_ready = 1'b1;

    aaar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    aaar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for the affine area-average resampler.
`timescale 1ns / 1ps

module tb;
    import aaar_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int NUM_DIRECTED = 16;
    localparam int NUM_PHASES = 11;
    localparam int ITEMS_PER_PHASE = 97;
    localparam longint Q_ONE = 65536;

    typedef struct packed {
        logic        defined;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pix_t;

    typedef struct {
        logic        cmd;
        logic [15:0] index;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] qx;
        logic [15:0] qy;
        bit          typed;
        pix_t        want;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  o_m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    affine_area_average_resampler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    // Predictor state: a shadow of the pixel store and of every register.
    logic [47:0] shadow_pix [STORE_DEPTH];
    bit          pix_written [STORE_DEPTH];
    longint      cxx, cxy, cyx, cyy, offx, offy;
    longint      img_w, img_h;

    pix_t        pending_pix [$];
    dir_row_t    dir_tab [NUM_DIRECTED];
    bit          no_idle;
    int          mismatches;
    int          results_seen;
    int          defined_seen;
    int          items_sent;
    int          cycle_count;

    // Clock: 8 ns period.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Abort on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !no_idle && ($urandom_range(99) < 38);
    endfunction

    // Stall the result side at random, change only on the falling edge.
    always @(negedge i_clk) begin
        m_tready <= !take_gap();
    end

    // Work out the result of one query from the shadow state.
    function automatic pix_t resample(input logic [15:0] qx_b, input logic [15:0] qy_b);
        longint w, h, px, py, sx, sy, ex, ey, t, wq, hq;
        longint row, col, top, bot, dy, lft, rgt, dx;
        logic [127:0] acc_r, acc_g, acc_b, area, ds, q;
        logic [47:0]  spix;
        int           a;
        pix_t         res;
        res   = '0;
        acc_r = '0;
        acc_g = '0;
        acc_b = '0;
        area  = '0;
        w  = (img_w > 256) ? 256 : img_w;
        h  = (img_h > 256) ? 256 : img_h;
        px = longint'($signed(qx_b));
        py = longint'($signed(qy_b));
        if (cxx == Q_ONE && cxy == 0 && cyx == 0 && cyy == Q_ONE &&
            offx == 0 && offy == 0) begin
            if (px < 0 || px >= w || py < 0 || py >= h) return res;
            spix = shadow_pix[int'(py * w + px)];
            res  = {1'b1, spix[15:0], spix[31:16], spix[47:32]};
            return res;
        end
        sx = cxx * px + cxy * py + offx;
        sy = cyx * px + cyy * py + offy;
        ex = cxx * (px + 1) + cxy * (py + 1) + offx;
        ey = cyx * (px + 1) + cyy * (py + 1) + offy;
        wq = w * Q_ONE;
        hq = h * Q_ONE;
        if (sx < 0 || sx >= wq || sy < 0 || sy >= hq || ex < 0 || ex >= wq ||
            ey < 0 || ey >= hq) return res;
        if (sx > ex) begin
            t = sx; sx = ex; ex = t;
        end
        if (sy > ey) begin
            t = sy; sy = ey; ey = t;
        end
        res.defined = 1'b1;
        for (row = sy / Q_ONE; row <= ey / Q_ONE; row++) begin
            top = row * Q_ONE;
            bot = top + Q_ONE;
            dy  = ((bot > ey) ? ey : bot) - ((top < sy) ? sy : top);
            for (col = sx / Q_ONE; col <= ex / Q_ONE; col++) begin
                lft = col * Q_ONE;
                rgt = lft + Q_ONE;
                dx  = ((rgt > ex) ? ex : rgt) - ((lft < sx) ? sx : lft);
                ds  = 128'(dx * dy);
                a   = int'(row * w + col);
                spix  = shadow_pix[a];
                acc_r = acc_r + ds * spix[15:0];
                acc_g = acc_g + ds * spix[31:16];
                acc_b = acc_b + ds * spix[47:32];
                area  = area + ds;
            end
        end
        // A degenerate box keeps zero channels.
        if (area != 0) begin
            q = acc_r / area;
            res.red   = (q > 65535) ? 16'hFFFF : q[15:0];
            q = acc_g / area;
            res.green = (q > 65535) ? 16'hFFFF : q[15:0];
            q = acc_b / area;
            res.blue  = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        return res;
    endfunction

    // Offer one input transaction and hold it until the block takes it.
    task automatic push_item(input logic cmd, input logic [15:0] index,
                             input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b, input logic [15:0] qx,
                             input logic [15:0] qy, input bit typed, input pix_t want);
        @(negedge i_clk);
        while (take_gap()) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {qy, qx, b, g, r, index};
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        if (cmd == CMD_LOAD) begin
            shadow_pix[index]  = {b, g, r};
            pix_written[index] = 1'b1;
        end else begin
            pending_pix.push_back(typed ? want : resample(qx, qy));
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COEF_XX:      cxx  = longint'($signed(value));
            CFG_COEF_XY:      cxy  = longint'($signed(value));
            CFG_COEF_YX:      cyx  = longint'($signed(value));
            CFG_COEF_YY:      cyy  = longint'($signed(value));
            CFG_OFFSET_X:     offx = longint'($signed(value));
            CFG_OFFSET_Y:     offy = longint'($signed(value));
            CFG_IMAGE_WIDTH:  img_w = longint'(value[8:0]);
            CFG_IMAGE_HEIGHT: img_h = longint'(value[8:0]);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every result has come, then let loads still in flight finish.
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_transform(input logic [31:0] xx, input logic [31:0] xy,
                                 input logic [31:0] yx, input logic [31:0] yy,
                                 input logic [31:0] ox, input logic [31:0] oy,
                                 input logic [31:0] w, input logic [31:0] h);
        write_reg(CFG_COEF_XX, xx);
        write_reg(CFG_COEF_XY, xy);
        write_reg(CFG_COEF_YX, yx);
        write_reg(CFG_COEF_YY, yy);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef(input int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Compare each result transaction with the oldest pending prediction.
    always @(posedge i_clk) begin
        pix_t got;
        pix_t want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = {o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32]};
            results_seen++;
            if (got.defined) defined_seen++;
            if (pending_pix.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_pix.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: want def=%b r=%h g=%h b=%h, got def=%b r=%h g=%h b=%h",
                                 results_seen, want.defined, want.red, want.green, want.blue,
                                 got.defined, got.red, got.green, got.blue);
                end
            end
        end
    end

    initial begin
        int   w_eff;
        int   h_eff;
        int   span;
        int   qx;
        int   qy;
        int   idx;
        logic [31:0] w_reg;
        logic [31:0] h_reg;
        pix_t none;

        none = '0;
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = CMD_LOAD;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr  = CFG_COEF_XX;
        cfg_data  = '0;
        no_idle   = 1'b0;
        mismatches = 0;
        results_seen = 0;
        defined_seen = 0;
        items_sent = 0;
        cycle_count = 0;
        cxx = Q_ONE; cxy = 0; cyx = 0; cyy = Q_ONE; offx = 0; offy = 0;
        img_w = 256; img_h = 256;
        for (int a = 0; a < STORE_DEPTH; a++) pix_written[a] = 1'b0;

        // Directed rows on the reset identity over a 256 x 256 image.
        dir_tab = '{
            '{CMD_LOAD, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'd0, 16'd0, 0, '0},
            '{CMD_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 0, '0},
            '{CMD_LOAD, 16'd257, 16'h1234, 16'hABCD, 16'h8001, 16'd0, 16'd0, 0, '0},
            '{CMD_LOAD, 16'd1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd0, 16'd0, 0, '0},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1, '{1'b1, 16'h0, 16'h0, 16'h0}},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd255, 16'd255, 1,
              '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 0, '0},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 1,
              '{1'b1, 16'hFFFF, 16'h0000, 16'hFFFF}},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1, '0},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 1, '0},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1, '0},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 1, '0},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 1, '0},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 1, '0},
            '{CMD_LOAD, 16'd0, 16'h5555, 16'hAAAA, 16'h7FFF, 16'd0, 16'd0, 0, '0},
            '{CMD_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0, '0}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            push_item(dir_tab[i].cmd, dir_tab[i].index, dir_tab[i].red, dir_tab[i].green,
                      dir_tab[i].blue, dir_tab[i].qx, dir_tab[i].qy, dir_tab[i].typed,
                      dir_tab[i].want);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Hold both sides busy for a whole phase once.
            no_idle = (p == 5);
            span = 98304;
            w_reg = 32'($urandom_range(16, 1));
            h_reg = 32'($urandom_range(16, 1));
            case (p)
                0: set_transform(ONE_Q16, 0, 0, ONE_Q16, 0, 0, 16, 8);
                1: set_transform(ONE_Q16, 0, 0, ONE_Q16, 0, 0, 256, 2);
                // Width above the maximum counts as the maximum.
                2: set_transform(ONE_Q16, 0, 0, ONE_Q16, 0, 0, 300, 3);
                // Zero width leaves every query undefined.
                3: set_transform(32'h0001_8000, 0, 0, ONE_Q16, 0, 0, 0, 5);
                // All-zero coefficients collapse the box to a point.
                4: set_transform(0, 0, 0, 0, 32'($urandom_range(w_reg * 65536 - 1)),
                                 32'($urandom_range(h_reg * 65536 - 1)), w_reg, h_reg);
                // Extreme coefficients that cancel along the diagonal.
                5: set_transform(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h0008_0000, 32'h0008_0000, 16, 16);
                6: set_transform(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h8000_0000, 12, 12);
                default: begin
                    if (p == NUM_PHASES - 1) span = 4 * 65536;
                    set_transform(rand_coef(span), rand_coef(span / 2), rand_coef(span / 2),
                                  rand_coef(span), 32'($urandom_range(w_reg * 65536 - 1)),
                                  32'($urandom_range(h_reg * 65536 - 1)), w_reg, h_reg);
                end
            endcase
            w_eff = (img_w > 256) ? 256 : int'(img_w);
            h_eff = (img_h > 256) ? 256 : int'(img_h);

            // Fill every entry a defined query of this setting can read.
            for (int a = 0; a < w_eff * h_eff; a++)
                if (!pix_written[a])
                    push_item(CMD_LOAD, 16'(a), rand_sample(), rand_sample(), rand_sample(),
                              16'($urandom), 16'($urandom), 0, none);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(9))
                    0, 1: begin
                        // Rewrite a pixel in use, or any address at all.
                        if ($urandom_range(1) && w_eff * h_eff > 0)
                            idx = $urandom_range(w_eff * h_eff - 1);
                        else
                            idx = $urandom_range(65535);
                        push_item(CMD_LOAD, 16'(idx), rand_sample(), rand_sample(),
                                  rand_sample(), 16'($urandom), 16'($urandom), 0, none);
                    end
                    2: push_item(CMD_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom), 0, none);
                    default: begin
                        qx = $urandom_range(w_eff + 4) - 2;
                        qy = ($urandom_range(2) == 0) ? qx : $urandom_range(h_eff + 4) - 2;
                        push_item(CMD_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'(qx), 16'(qy), 0, none);
                    end
                endcase
            end
            drain();
        end

        if (pending_pix.size() != 0) mismatches++;
        $display("run covered %0d input transactions over %0d register settings",
                 items_sent, NUM_PHASES + 1);
        $display("checked %0d results, %0d of them defined", results_seen, defined_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
src/aaar_pkg.sv
src/aaar_ctrl.sv
src/aaar_dp.sv
src/affine_area_average_resampler.sv
tb/tb.sv
